// ===== src/pec_pkg.sv =====
// Shared constants, register indexes and command types for the pointer event coalescer.
package pec_pkg;

    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_REL = 5'd2;
    localparam logic [4:0] EV_ABS = 5'd3;

    localparam logic [9:0] SYN_REPORT    = 10'h000;
    localparam logic [9:0] REL_X         = 10'h000;
    localparam logic [9:0] REL_Y         = 10'h001;
    localparam logic [9:0] ABS_X         = 10'h000;
    localparam logic [9:0] ABS_Y         = 10'h001;
    localparam logic [9:0] AXIS_PRESSURE = 10'h018;
    localparam logic [9:0] KEY_TOUCH     = 10'h14A;

    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_REL = 2'd1;
    localparam logic [1:0] KIND_ABS = 2'd2;

    localparam logic [2:0] REG_X_MIN    = 3'd0;
    localparam logic [2:0] REG_X_MAX    = 3'd1;
    localparam logic [2:0] REG_Y_MIN    = 3'd2;
    localparam logic [2:0] REG_Y_MAX    = 3'd3;
    localparam logic [2:0] REG_P_MAX    = 3'd4;
    localparam logic [2:0] REG_SWAP     = 3'd5;
    localparam logic [2:0] REG_MIRROR_X = 3'd6;
    localparam logic [2:0] REG_MIRROR_Y = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] x_min;
        logic signed [15:0] x_max;
        logic signed [15:0] y_min;
        logic signed [15:0] y_max;
        logic [15:0]        p_max;
        logic               swap;
        logic               mirror_x;
        logic               mirror_y;
    } cfg_t;

    typedef struct packed {
        logic key;
        logic rel;
        logic abs;
        logic touch;
    } cmd_flags_t;

    typedef struct packed {
        cmd_flags_t         flags;
        logic [9:0]         code;
        logic signed [31:0] value;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        span_x;
        logic [15:0]        span_y;
        logic signed [31:0] pressure;
    } cmd_t;

endpackage

// ===== src/pec_fifo.sv =====
// Short command queue between the event front end and the record back end.
module pec_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pec_pkg::cmd_t push_data,
    input  logic          pop,
    output pec_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    pec_pkg::cmd_t                     entry_reg [pec_pkg::QUEUE_DEPTH];
    logic [pec_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [pec_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [pec_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [pec_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [pec_pkg::QCNT_W-1:0]        count_reg;
    logic [pec_pkg::QCNT_W-1:0]        count_next;

    localparam logic [pec_pkg::QPTR_W-1:0] PTR_LAST = pec_pkg::QPTR_W'(pec_pkg::QUEUE_DEPTH - 1);
    localparam logic [pec_pkg::QCNT_W-1:0] CNT_FULL = pec_pkg::QCNT_W'(pec_pkg::QUEUE_DEPTH);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ===== src/pec_front.sv =====
// Front end: accepts events, latches axis state and queues record commands.
module pec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  pec_pkg::cfg_t       cfg,
    input  logic                event_valid,
    input  logic [4:0]          event_type,
    input  logic [9:0]          event_code,
    input  logic signed [31:0]  event_value,
    output logic                event_stall,
    input  logic                q_full,
    output logic                push,
    output pec_pkg::cmd_t       push_data
);

    logic signed [31:0] delta_x_reg, delta_x_next;
    logic signed [31:0] delta_y_reg, delta_y_next;
    logic signed [31:0] abs_x_reg, abs_x_next;
    logic signed [31:0] abs_y_reg, abs_y_next;
    logic signed [31:0] pressure_reg, pressure_next;
    logic               rel_seen_reg, rel_seen_next;
    logic               x_seen_reg, x_seen_next;
    logic               y_seen_reg, y_seen_next;
    logic               touch_pending_reg, touch_pending_next;
    logic               accept;
    logic [31:0]        clip_x;
    logic [31:0]        clip_y;

    // returns {offset position, span}, both modulo 2^16
    function automatic logic [31:0] clip_axis(input logic signed [31:0] v,
                                              input logic signed [15:0] lo,
                                              input logic signed [15:0] hi);
        logic signed [31:0] lo_w;
        logic signed [31:0] hi_w;
        logic [15:0]        c;
        lo_w = {{16{lo[15]}}, lo};
        hi_w = {{16{hi[15]}}, hi};
        if (v > hi_w)
        begin
            c = (hi_w < lo_w) ? lo : hi;
        end
        else
        begin
            c = (v < lo_w) ? lo : v[15:0];
        end
        return {c - lo, hi - lo};
    endfunction

    assign event_stall = q_full;
    assign accept      = event_valid && !q_full;
    assign clip_x      = clip_axis(abs_x_reg, cfg.x_min, cfg.x_max);
    assign clip_y      = clip_axis(abs_y_reg, cfg.y_min, cfg.y_max);

    always_comb
    begin
        delta_x_next       = delta_x_reg;
        delta_y_next       = delta_y_reg;
        abs_x_next         = abs_x_reg;
        abs_y_next         = abs_y_reg;
        pressure_next      = pressure_reg;
        rel_seen_next      = rel_seen_reg;
        x_seen_next        = x_seen_reg;
        y_seen_next        = y_seen_reg;
        touch_pending_next = touch_pending_reg;
        push               = 1'b0;
        push_data          = '0;
        if (accept)
        begin
            case (event_type)
                pec_pkg::EV_REL:
                begin
                    if (event_code == pec_pkg::REL_X)
                    begin
                        delta_x_next  = event_value;
                        rel_seen_next = 1'b1;
                    end
                    else if (event_code == pec_pkg::REL_Y)
                    begin
                        delta_y_next  = event_value;
                        rel_seen_next = 1'b1;
                    end
                end
                pec_pkg::EV_ABS:
                begin
                    if (event_code == pec_pkg::ABS_X)
                    begin
                        abs_x_next  = event_value;
                        x_seen_next = 1'b1;
                    end
                    else if (event_code == pec_pkg::ABS_Y)
                    begin
                        abs_y_next  = event_value;
                        y_seen_next = 1'b1;
                    end
                    else if (event_code == pec_pkg::AXIS_PRESSURE)
                    begin
                        pressure_next = event_value;
                    end
                end
                pec_pkg::EV_KEY:
                begin
                    // touch-down is held back until the next absolute record
                    if (!(event_code == pec_pkg::KEY_TOUCH && event_value != 0))
                    begin
                        push                = 1'b1;
                        push_data.flags.key = 1'b1;
                        push_data.code      = event_code;
                        push_data.value     = event_value;
                        if (event_code == pec_pkg::KEY_TOUCH)
                        begin
                            touch_pending_next = 1'b1;
                        end
                    end
                end
                pec_pkg::EV_SYN:
                begin
                    if (event_code == pec_pkg::SYN_REPORT
                        && (rel_seen_reg || x_seen_reg || y_seen_reg))
                    begin
                        push = 1'b1;
                        if (rel_seen_reg)
                        begin
                            push_data.flags.rel = 1'b1;
                            push_data.delta_x   = delta_x_reg;
                            push_data.delta_y   = delta_y_reg;
                            rel_seen_next       = 1'b0;
                            delta_x_next        = '0;
                            delta_y_next        = '0;
                        end
                        if (x_seen_reg || y_seen_reg)
                        begin
                            push_data.flags.abs   = 1'b1;
                            push_data.flags.touch = touch_pending_reg;
                            push_data.pressure    = pressure_reg;
                            if (x_seen_reg)
                            begin
                                push_data.pos_x  = clip_x[31:16];
                                push_data.span_x = clip_x[15:0];
                            end
                            if (y_seen_reg)
                            begin
                                push_data.pos_y  = clip_y[31:16];
                                push_data.span_y = clip_y[15:0];
                            end
                            x_seen_next        = 1'b0;
                            y_seen_next        = 1'b0;
                            pressure_next      = '0;
                            touch_pending_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_x_reg       <= '0;
            delta_y_reg       <= '0;
            abs_x_reg         <= '0;
            abs_y_reg         <= '0;
            pressure_reg      <= '0;
            rel_seen_reg      <= 1'b0;
            x_seen_reg        <= 1'b0;
            y_seen_reg        <= 1'b0;
            touch_pending_reg <= 1'b1;
        end
        else
        begin
            delta_x_reg       <= delta_x_next;
            delta_y_reg       <= delta_y_next;
            abs_x_reg         <= abs_x_next;
            abs_y_reg         <= abs_y_next;
            pressure_reg      <= pressure_next;
            rel_seen_reg      <= rel_seen_next;
            x_seen_reg        <= x_seen_next;
            y_seen_reg        <= y_seen_next;
            touch_pending_reg <= touch_pending_next;
        end
    end

    a_touch_with_abs: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.flags.touch |-> push_data.flags.abs)
        else $error("deferred touch queued without absolute record");
    a_key_alone: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.flags.key |-> !push_data.flags.rel && !push_data.flags.abs)
        else $error("key command mixed with motion");
    a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.flags.abs |=> !x_seen_reg && !y_seen_reg && pressure_reg == 0)
        else $error("absolute state not cleared after sync");

endmodule

// ===== src/pec_back.sv =====
// Back end: queued commands become records, one per cycle unless stalled.
module pec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pec_pkg::cfg_t       cfg,
    input  pec_pkg::cmd_t       head,
    input  logic                empty,
    output logic                pop,
    output logic                record_valid,
    input  logic                record_stall,
    output logic [1:0]          record_kind,
    output logic [9:0]          key_code,
    output logic signed [31:0]  key_state,
    output logic signed [31:0]  delta_x,
    output logic signed [31:0]  delta_y,
    output logic [15:0]         position_x,
    output logic [15:0]         position_y,
    output logic signed [31:0]  pressure,
    output logic [15:0]         span_x,
    output logic [15:0]         span_y,
    output logic [15:0]         pressure_span,
    output logic                last_of_run
);

    pec_pkg::cmd_flags_t done_reg, done_next;
    pec_pkg::cmd_flags_t pend;
    pec_pkg::cmd_flags_t sel;
    logic                load;
    logic                last;
    logic [15:0]         px, py, sx, sy;

    logic                valid_reg;
    logic [1:0]          kind_reg, kind_next;
    logic [9:0]          code_reg, code_next;
    logic signed [31:0]  state_reg, state_next;
    logic signed [31:0]  dx_reg, dx_next;
    logic signed [31:0]  dy_reg, dy_next;
    logic [15:0]         posx_reg, posx_next;
    logic [15:0]         posy_reg, posy_next;
    logic signed [31:0]  press_reg, press_next;
    logic [15:0]         spanx_reg, spanx_next;
    logic [15:0]         spany_reg, spany_next;
    logic [15:0]         pspan_reg, pspan_next;
    logic                last_reg;

    assign pend = head.flags & ~done_reg;
    assign load = !empty && (!valid_reg || !record_stall);

    always_comb
    begin
        sel = '0;
        if (pend.key)
        begin
            sel.key = 1'b1;
        end
        else if (pend.rel)
        begin
            sel.rel = 1'b1;
        end
        else if (pend.abs)
        begin
            sel.abs = 1'b1;
        end
        else if (pend.touch)
        begin
            sel.touch = 1'b1;
        end
    end

    assign last = ((pend & ~sel) == '0);
    assign pop  = load && last;

    always_comb
    begin
        sx = cfg.swap ? head.span_y : head.span_x;
        sy = cfg.swap ? head.span_x : head.span_y;
        px = cfg.swap ? head.pos_y : head.pos_x;
        py = cfg.swap ? head.pos_x : head.pos_y;
        if (cfg.mirror_x)
        begin
            px = sx - px;
        end
        if (cfg.mirror_y)
        begin
            py = sy - py;
        end
    end

    always_comb
    begin
        kind_next  = pec_pkg::KIND_KEY;
        code_next  = '0;
        state_next = '0;
        dx_next    = '0;
        dy_next    = '0;
        posx_next  = '0;
        posy_next  = '0;
        press_next = '0;
        spanx_next = '0;
        spany_next = '0;
        pspan_next = '0;
        if (sel.key)
        begin
            code_next  = head.code;
            state_next = head.value;
        end
        else if (sel.rel)
        begin
            kind_next = pec_pkg::KIND_REL;
            dx_next   = head.delta_x;
            dy_next   = head.delta_y;
        end
        else if (sel.abs)
        begin
            kind_next  = pec_pkg::KIND_ABS;
            posx_next  = px;
            posy_next  = py;
            press_next = head.pressure;
            spanx_next = sx;
            spany_next = sy;
            pspan_next = cfg.p_max;
        end
        else if (sel.touch)
        begin
            code_next  = pec_pkg::KEY_TOUCH;
            state_next = 32'sd1;
        end
        done_next = done_reg;
        if (load)
        begin
            done_next = last ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!record_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            code_reg  <= code_next;
            state_reg <= state_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            press_reg <= press_next;
            spanx_reg <= spanx_next;
            spany_reg <= spany_next;
            pspan_reg <= pspan_next;
            last_reg  <= last;
        end
    end

    assign record_valid  = valid_reg;
    assign record_kind   = kind_reg;
    assign key_code      = code_reg;
    assign key_state     = state_reg;
    assign delta_x       = dx_reg;
    assign delta_y       = dy_reg;
    assign position_x    = posx_reg;
    assign position_y    = posy_reg;
    assign pressure      = press_reg;
    assign span_x        = spanx_reg;
    assign span_y        = spany_reg;
    assign pressure_span = pspan_reg;
    assign last_of_run   = last_reg;

    a_idle_progress: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> done_reg == '0)
        else $error("progress mask set with empty queue");
    a_work_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pend != '0 && (done_reg & ~head.flags) == '0)
        else $error("queued command has no record left");
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> record_valid && last_of_run)
        else $error("command retired without final record");

endmodule

// ===== src/pointer_event_coalescer.sv =====
// Top level of the pointer event coalescer: configuration registers and front/queue/back.
//
// Event channel (event_valid/event_stall): one evdev event per beat. Relative,
// absolute and pressure values are latched; key beats other than a touch-down pass
// through; a sync with code 0 flushes the latched axes as up to three records.
// Record channel (record_valid/record_stall): one record per beat, with
// last_of_run marking the final record caused by an event.
// Configuration: cfg_write with cfg_index/cfg_data, taken at the clock edge;
// the user must write only while no work is in flight; the block does not enforce this.
// Path: an event's command enters the queue, then the back-end record registers.
// Throughput: one event per cycle unless event_stall; the back end issues one
// record per cycle unless record_stall, so a sync's relative, absolute and touch
// records come in turn. A two-entry command queue sits between front and back.
// Reset: latched state and configuration registers clear, the touch-down is
// pending, the queue empties and record_valid drops.
// Stall: a stalled record holds; the queue fills and then event_stall rises.
module pointer_event_coalescer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                event_valid,
    output logic                event_stall,
    input  logic [4:0]          event_type,
    input  logic [9:0]          event_code,
    input  logic signed [31:0]  event_value,
    output logic                record_valid,
    input  logic                record_stall,
    output logic [1:0]          record_kind,
    output logic [9:0]          key_code,
    output logic signed [31:0]  key_state,
    output logic signed [31:0]  delta_x,
    output logic signed [31:0]  delta_y,
    output logic [15:0]         position_x,
    output logic [15:0]         position_y,
    output logic signed [31:0]  pressure,
    output logic [15:0]         span_x,
    output logic [15:0]         span_y,
    output logic [15:0]         pressure_span,
    output logic                last_of_run
);

    pec_pkg::cfg_t cfg_reg;
    pec_pkg::cmd_t push_data;
    pec_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pec_pkg::REG_X_MIN:    cfg_reg.x_min    <= cfg_data;
                pec_pkg::REG_X_MAX:    cfg_reg.x_max    <= cfg_data;
                pec_pkg::REG_Y_MIN:    cfg_reg.y_min    <= cfg_data;
                pec_pkg::REG_Y_MAX:    cfg_reg.y_max    <= cfg_data;
                pec_pkg::REG_P_MAX:    cfg_reg.p_max    <= cfg_data;
                pec_pkg::REG_SWAP:     cfg_reg.swap     <= cfg_data[0];
                pec_pkg::REG_MIRROR_X: cfg_reg.mirror_x <= cfg_data[0];
                pec_pkg::REG_MIRROR_Y: cfg_reg.mirror_y <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .event_valid (event_valid),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .event_stall (event_stall),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    pec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pec_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .record_valid  (record_valid),
        .record_stall  (record_stall),
        .record_kind   (record_kind),
        .key_code      (key_code),
        .key_state     (key_state),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .position_x    (position_x),
        .position_y    (position_y),
        .pressure      (pressure),
        .span_x        (span_x),
        .span_y        (span_y),
        .pressure_span (pressure_span),
        .last_of_run   (last_of_run)
    );

endmodule
